[rtl/epoch_seconds_to_calendar_assert.svh]
// Assertion helpers shared by the calendar pipeline.
// ESC_ASSERT_IMP checks the consequent in the same cycle as the antecedent.
// ESC_ASSERT_NXT checks the consequent in the cycle after the antecedent.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/esc_pkg.sv]
package esc_pkg;

  typedef struct packed {
    logic vld;
    logic ok;
  } esc_ctl_t;

  // window bounds in Unix seconds
  localparam logic [31:0] WIN_LO = 32'd1735689600;
  localparam logic [31:0] WIN_HI = 32'd2082758400;

  localparam int OFS_W = 29;
  localparam int DAY_W = 12;
  localparam int SOD_W = 17;
  localparam int DOE_W = 14;

  localparam logic [SOD_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;

  // day 0 of the window is day 9072 of 400-year era 5 (from 2000-03-01)
  localparam logic [DOE_W-1:0] DOE_BIAS  = 14'd9072;
  // weekday offset of the window start, Sunday counted as zero
  localparam logic [DAY_W-1:0] WD_BIAS   = 12'd3;
  localparam logic [10:0]      YEAR_BASE = 11'd2000;

  // ceiling reciprocals, exact over the value ranges they see
  localparam logic [22:0] RECIP_675  = 23'd6362915;   // 2^32 / 675
  localparam logic [13:0] RECIP_1460 = 14'd11492;     // 2^24 / 1460
  localparam logic [13:0] RECIP_7    = 14'd9363;      // 2^16 / 7
  localparam logic [15:0] RECIP_365  = 16'd45965;     // 2^24 / 365
  localparam logic [12:0] RECIP_153  = 13'd6854;      // 2^20 / 153
  localparam logic [20:0] RECIP_3600 = 21'd1193047;   // 2^32 / 3600
  localparam logic [14:0] RECIP_60   = 15'd17477;     // 2^20 / 60

  // first day of each March-based month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/esc_split.sv]
module esc_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [31:0]                 in_secs,
  output esc_pkg::esc_ctl_t           ctl_o,
  output logic [esc_pkg::SOD_W-1:0]   sod_o,
  output logic [esc_pkg::DOE_W-1:0]   doe_o,
  output logic [esc_pkg::DAY_W-1:0]   wx_o
);

  esc_pkg::esc_ctl_t ctl1_r, ctl2_r, ctl3_r;
  esc_pkg::esc_ctl_t ctl1_nxt;

  logic [esc_pkg::OFS_W-1:0] ofs1_r, ofs2_r;
  logic [esc_pkg::OFS_W-1:0] ofs1_nxt;
  logic [esc_pkg::DAY_W-1:0] day2_r, day2_nxt;
  logic [44:0]               day_prod;
  logic [esc_pkg::OFS_W-1:0] day_secs;
  logic [esc_pkg::OFS_W-1:0] sod_full;
  logic [esc_pkg::SOD_W-1:0] sod3_r, sod3_nxt;
  logic [esc_pkg::DOE_W-1:0] doe3_r, doe3_nxt;
  logic [esc_pkg::DAY_W-1:0] wx3_r, wx3_nxt;
  logic [31:0]               ofs_full;

  // stage 1: window check and offset from the window start
  always_comb begin
    ctl1_nxt.vld = in_vld;
    ctl1_nxt.ok  = (in_secs >= esc_pkg::WIN_LO) && (in_secs < esc_pkg::WIN_HI);
    ofs_full     = in_secs - esc_pkg::WIN_LO;
    ofs1_nxt     = ofs_full[esc_pkg::OFS_W-1:0];
  end

  // stage 2: whole days, offset / 86400 = (offset >> 7) / 675
  always_comb begin
    day_prod = 45'(ofs1_r[esc_pkg::OFS_W-1:7]) * 45'(esc_pkg::RECIP_675);
    day2_nxt = day_prod[43:32];
  end

  // stage 3: second of day and day-count biases
  always_comb begin
    day_secs = esc_pkg::OFS_W'(day2_r) * esc_pkg::OFS_W'(esc_pkg::SECS_PER_DAY);
    sod_full = ofs2_r - day_secs;
    sod3_nxt = sod_full[esc_pkg::SOD_W-1:0];
    doe3_nxt = esc_pkg::DOE_W'(day2_r) + esc_pkg::DOE_BIAS;
    wx3_nxt  = day2_r + esc_pkg::WD_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    ofs1_r <= ofs1_nxt;
    ofs2_r <= ofs1_r;
    day2_r <= day2_nxt;
    sod3_r <= sod3_nxt;
    doe3_r <= doe3_nxt;
    wx3_r  <= wx3_nxt;
  end

  assign ctl_o = ctl3_r;
  assign sod_o = sod3_r;
  assign doe_o = doe3_r;
  assign wx_o  = wx3_r;

endmodule

[rtl/esc_tod.sv]
module esc_tod (
  input  logic                      clk,
  input  logic [esc_pkg::SOD_W-1:0] sod_i,
  output logic [4:0]                hour_o,
  output logic [5:0]                minute_o,
  output logic [5:0]                second_o
);

  logic [37:0]               hour_prod;
  logic [4:0]                hour1_r, hour2_r, hour3_r, hour4_r, hour5_r, hour6_r;
  logic [4:0]                hour1_nxt;
  logic [esc_pkg::SOD_W-1:0] sod1_r;
  logic [esc_pkg::SOD_W-1:0] hour_secs;
  logic [esc_pkg::SOD_W-1:0] rem_full;
  logic [11:0]               rem2_r, rem3_r;
  logic [11:0]               rem2_nxt;
  logic [26:0]               min_prod;
  logic [5:0]                min3_r, min4_r, min5_r, min6_r;
  logic [5:0]                min3_nxt;
  logic [11:0]               sec_full;
  logic [5:0]                sec4_r, sec5_r, sec6_r;
  logic [5:0]                sec4_nxt;

  always_comb begin
    hour_prod = 38'(sod_i) * 38'(esc_pkg::RECIP_3600);
    hour1_nxt = hour_prod[36:32];
    hour_secs = esc_pkg::SOD_W'(hour1_r) * esc_pkg::SOD_W'(esc_pkg::SECS_PER_HOUR);
    rem_full  = sod1_r - hour_secs;
    rem2_nxt  = rem_full[11:0];
    min_prod  = 27'(rem2_r) * 27'(esc_pkg::RECIP_60);
    min3_nxt  = min_prod[25:20];
    sec_full  = rem3_r - 12'(min3_r) * 12'd60;
    sec4_nxt  = sec_full[5:0];
  end

  // hold results two extra stages to line up with the date path
  always_ff @(posedge clk) begin
    hour1_r <= hour1_nxt;
    sod1_r  <= sod_i;
    hour2_r <= hour1_r;
    rem2_r  <= rem2_nxt;
    hour3_r <= hour2_r;
    rem3_r  <= rem2_r;
    min3_r  <= min3_nxt;
    hour4_r <= hour3_r;
    min4_r  <= min3_r;
    sec4_r  <= sec4_nxt;
    hour5_r <= hour4_r;
    min5_r  <= min4_r;
    sec5_r  <= sec4_r;
    hour6_r <= hour5_r;
    min6_r  <= min5_r;
    sec6_r  <= sec5_r;
  end

  assign hour_o   = hour6_r;
  assign minute_o = min6_r;
  assign second_o = sec6_r;

endmodule

[rtl/esc_date.sv]
`include "epoch_seconds_to_calendar_assert.svh"

module esc_date (
  input  logic                      clk,
  input  logic                      rst_n,
  input  esc_pkg::esc_ctl_t         ctl_i,
  input  logic [esc_pkg::DOE_W-1:0] doe_i,
  input  logic [esc_pkg::DAY_W-1:0] wx_i,
  output esc_pkg::esc_ctl_t         ctl_o,
  output logic [10:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o,
  output logic [2:0]                weekday_o
);

  esc_pkg::esc_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;

  logic [27:0]               q1_prod;
  logic [25:0]               wq_prod;
  logic [3:0]                q1_r, q1_nxt;
  logic [9:0]                wq_r, wq_nxt;
  logic [esc_pkg::DOE_W-1:0] doe1_r, doe2_r, doe3_r;
  logic [esc_pkg::DAY_W-1:0] wx1_r;
  logic [esc_pkg::DOE_W-1:0] a2_r, a2_nxt;
  logic [esc_pkg::DAY_W-1:0] wrem;
  logic [2:0]                wd2_r, wd3_r, wd4_r, wd5_r, wd6_r;
  logic [2:0]                wd2_nxt;
  logic [29:0]               yoe_prod;
  logic [5:0]                yoe3_r, yoe4_r, yoe5_r;
  logic [5:0]                yoe3_nxt;
  logic [esc_pkg::DOE_W-1:0] doy_full;
  logic [8:0]                doy4_r, doy5_r;
  logic [8:0]                doy4_nxt;
  logic [10:0]               mp_arg;
  logic [23:0]               mp_prod;
  logic [3:0]                mp5_r, mp5_nxt;
  logic [8:0]                day_full;
  logic [3:0]                month_nxt;
  logic [4:0]                day_nxt;
  logic [10:0]               year_nxt;
  logic [10:0]               year6_r;
  logic [3:0]                month6_r;
  logic [4:0]                day6_r;

  always_comb begin
    // stage 1: doe / 1460 and weekday quotient
    q1_prod  = 28'(doe_i) * 28'(esc_pkg::RECIP_1460);
    q1_nxt   = q1_prod[27:24];
    wq_prod  = 26'(wx_i) * 26'(esc_pkg::RECIP_7);
    wq_nxt   = wq_prod[25:16];
    // stage 2: leap correction and weekday remainder
    a2_nxt   = doe1_r - esc_pkg::DOE_W'(q1_r);
    wrem     = wx1_r - esc_pkg::DAY_W'(wq_r) * 12'd7;
    wd2_nxt  = wrem[2:0] + 3'd1;
    // stage 3: year of era
    yoe_prod = 30'(a2_r) * 30'(esc_pkg::RECIP_365);
    yoe3_nxt = yoe_prod[29:24];
    // stage 4: day of March-based year
    doy_full = doe3_r - esc_pkg::DOE_W'(yoe3_r) * 14'd365 - esc_pkg::DOE_W'(yoe3_r >> 2);
    doy4_nxt = doy_full[8:0];
    // stage 5: March-based month
    mp_arg   = (11'(doy4_r) << 2) + 11'(doy4_r) + 11'd2;
    mp_prod  = 24'(mp_arg) * 24'(esc_pkg::RECIP_153);
    mp5_nxt  = mp_prod[23:20];
    // stage 6: civil day, month and year
    day_full  = doy5_r - esc_pkg::month_start(mp5_r) + 9'd1;
    day_nxt   = day_full[4:0];
    month_nxt = (mp5_r < 4'd10) ? (mp5_r + 4'd3) : (mp5_r - 4'd9);
    year_nxt  = esc_pkg::YEAR_BASE + 11'(yoe5_r) + 11'(month_nxt <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    q1_r     <= q1_nxt;
    wq_r     <= wq_nxt;
    doe1_r   <= doe_i;
    wx1_r    <= wx_i;
    a2_r     <= a2_nxt;
    doe2_r   <= doe1_r;
    wd2_r    <= wd2_nxt;
    yoe3_r   <= yoe3_nxt;
    doe3_r   <= doe2_r;
    wd3_r    <= wd2_r;
    doy4_r   <= doy4_nxt;
    yoe4_r   <= yoe3_r;
    wd4_r    <= wd3_r;
    mp5_r    <= mp5_nxt;
    doy5_r   <= doy4_r;
    yoe5_r   <= yoe4_r;
    wd5_r    <= wd4_r;
    year6_r  <= year_nxt;
    month6_r <= month_nxt;
    day6_r   <= day_nxt;
    wd6_r    <= wd5_r;
  end

  assign ctl_o     = ctl6_r;
  assign year_o    = year6_r;
  assign month_o   = month6_r;
  assign day_o     = day6_r;
  assign weekday_o = wd6_r;

  `ESC_ASSERT_NXT(a_wd_nonzero, clk, rst_n, ctl1_r.vld && ctl1_r.ok, wd2_r != 3'd0,
                  "weekday remainder out of range")

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// Unix seconds to calendar date and time of day, window 2025 through 2035.
//
// Input channel: drive in_epoch_seconds and raise start; the word is taken at
// a rising edge where start is high and busy is low. busy is high only while
// rst_n is low and up to the edge after it rises, so one word a cycle is taken.
// Result channel: out_strobe marks the single cycle in which a result word is
// on the out_ ports; it is consumed at the edge closing that cycle and the
// receiver has no way to hold it off, so nothing in the pipe ever stalls.
// Path: a word accepted at a rising edge reaches the ports through nine
// register stages: three in the day/second split, six in the date path,
// with the time-of-day path padded to the same depth. Throughput is one
// word per cycle: every stage advances on every edge and none ever waits.
// Out-of-window words give out_valid_res low and every date and time field zero.
// Reset (synchronous, active low) clears all stage valid bits; words in
// flight are dropped and no strobe follows until new words are taken.
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [10:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  logic busy_r, busy_nxt;
  logic take;

  esc_pkg::esc_ctl_t         split_ctl;
  esc_pkg::esc_ctl_t         date_ctl;
  logic [esc_pkg::SOD_W-1:0] sod;
  logic [esc_pkg::DOE_W-1:0] doe;
  logic [esc_pkg::DAY_W-1:0] wx;
  logic [10:0]               year;
  logic [3:0]                month;
  logic [4:0]                day;
  logic [2:0]                weekday;
  logic [4:0]                hour;
  logic [5:0]                minute;
  logic [5:0]                second;

  // hold off input through reset, clearing busy at the first edge after release
  assign busy_nxt = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign take = start && !busy_r;

  // stages 1..3: window check, split into days and second of day
  esc_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (take),
    .in_secs (in_epoch_seconds),
    .ctl_o   (split_ctl),
    .sod_o   (sod),
    .doe_o   (doe),
    .wx_o    (wx)
  );

  // stages 4..9: civil date and weekday; carries the valid bits
  esc_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (split_ctl),
    .doe_i     (doe),
    .wx_i      (wx),
    .ctl_o     (date_ctl),
    .year_o    (year),
    .month_o   (month),
    .day_o     (day),
    .weekday_o (weekday)
  );

  // stages 4..9: hour, minute, second
  esc_tod u_tod (
    .clk      (clk),
    .sod_i    (sod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  // zero every field for words outside the window
  always_comb begin
    out_strobe    = date_ctl.vld;
    out_valid_res = date_ctl.ok;
    if (date_ctl.ok) begin
      out_year         = year;
      out_month        = month;
      out_day_of_month = day;
      out_hour         = hour;
      out_minute       = minute;
      out_second       = second;
      out_weekday      = weekday;
    end else begin
      out_year         = '0;
      out_month        = '0;
      out_day_of_month = '0;
      out_hour         = '0;
      out_minute       = '0;
      out_second       = '0;
      out_weekday      = '0;
    end
  end

  `ESC_ASSERT_IMP(a_date_range, clk, rst_n, out_strobe && out_valid_res,
                  (out_year >= 11'd2025) && (out_year <= 11'd2035) &&
                  (out_month >= 4'd1) && (out_month <= 4'd12) &&
                  (out_day_of_month >= 5'd1) && (out_weekday != 3'd0),
                  "calendar date out of range")
  `ESC_ASSERT_IMP(a_time_range, clk, rst_n, out_strobe && out_valid_res,
                  (out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60),
                  "time of day out of range")
  `ESC_ASSERT_IMP(a_feb_len, clk, rst_n,
                  out_strobe && out_valid_res && (out_month == 4'd2),
                  out_day_of_month <= 5'd29, "february day past 29")

endmodule
